[rtl/yuv_to_rgb_rotate_writer_defines.svh]
// assertion macros for the checker file of yuv_to_rgb_rotate_writer
// no dependencies; each macro expects clk and rst in the using scope
`ifndef YUV_TO_RGB_ROTATE_WRITER_DEFINES_SVH
`define YUV_TO_RGB_ROTATE_WRITER_DEFINES_SVH

// consequent checked in the same cycle
`define YRW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define YRW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/yrw_pkg.sv]
// shared types, constants and helpers for the yuv to rgb rotate writer
// no dependencies
package yrw_pkg;

  // parameter defaults
  localparam int MAX_DIM_DEFAULT     = 4096;
  localparam int MAX_STRIDE_DEFAULT  = 8192;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  // register file layout
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int ROT_W       = 2;
  localparam int REGION_W    = 13;
  localparam int STRIDE_W    = 14;

  localparam logic [CFG_INDEX_W-1:0] REG_ROTATION      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_HEIGHT = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_STRIDE    = 2'd3;

  localparam logic [ROT_W-1:0]    ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0]    ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0]    ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0]    ROT_270 = 2'd3;

  localparam logic [REGION_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [REGION_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 14'd640;

  // output index width
  localparam int IDX_W = 25;

  // color math, scaled by 1024
  localparam int CH_W       = 22;
  localparam int CHAN_SHIFT = 10;
  localparam logic [7:0] LUMA_OFFSET = 8'd16;
  localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;
  localparam logic signed [CH_W-1:0] COEF_Y  = 22'sd1192;
  localparam logic signed [CH_W-1:0] COEF_RV = 22'sd1634;
  localparam logic signed [CH_W-1:0] COEF_GV = 22'sd833;
  localparam logic signed [CH_W-1:0] COEF_GU = 22'sd400;
  localparam logic signed [CH_W-1:0] COEF_BU = 22'sd2066;
  localparam logic signed [CH_W-1:0] CHAN_MAX = 22'sd262143;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  typedef struct packed {
    logic [7:0] luma_sample;
    logic [7:0] blue_diff_sample;
    logic [7:0] red_diff_sample;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] dest_index;
    logic [31:0]      pixel_rgba;
    logic             frame_done;
  } out_item_t;

  // pixel plus its end-of-frame mark, as classified by the front
  typedef struct packed {
    in_item_t pix;
    logic     frame_done;
  } pix_class_t;

  // clamp a scaled channel to 0..262143 and take the 8-bit value
  function automatic logic [7:0] clamp_chan(input logic signed [CH_W-1:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > CHAN_MAX) begin
      return 8'hff;
    end else begin
      return v[CHAN_SHIFT+7:CHAN_SHIFT];
    end
  endfunction

endpackage

[rtl/yrw_stream_if.sv]
// valid/ready channels for source pixels and rgba results
// depends on yrw_pkg for the payload structs
interface yrw_pixel_if;
  logic              valid;
  logic              ready;
  yrw_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface yrw_result_if;
  logic               valid;
  logic               ready;
  yrw_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[rtl/yrw_front.sv]
// front: config registers, row/column tracking and index operand selection
// depends on yrw_pkg and yrw_pixel_if
module yrw_front #(
  parameter int MAX_DIM    = yrw_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_STRIDE = yrw_pkg::MAX_STRIDE_DEFAULT,
  localparam int CNT_W     = $clog2(MAX_DIM),
  localparam int STR_W     = $clog2(MAX_STRIDE) + 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [yrw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yrw_pkg::CFG_DATA_W-1:0]  cfg_data,
  yrw_pixel_if.sink                       pix_in,
  output logic                            q_valid,
  input  logic                            q_ready,
  output yrw_pkg::pix_class_t             q_pix,
  output logic [CNT_W-1:0]                q_mul_a,
  output logic [CNT_W-1:0]                q_add_b,
  output logic [STR_W-1:0]                q_stride
);

  localparam int DIM_W = CNT_W + 1;
  localparam int WCMP  = (DIM_W > yrw_pkg::REGION_W) ? DIM_W : yrw_pkg::REGION_W;
  localparam int SCMP  = (STR_W > yrw_pkg::STRIDE_W) ? STR_W : yrw_pkg::STRIDE_W;

  logic [yrw_pkg::ROT_W-1:0]    rotation;
  logic [yrw_pkg::REGION_W-1:0] region_width;
  logic [yrw_pkg::REGION_W-1:0] region_height;
  logic [yrw_pkg::STRIDE_W-1:0] row_stride;
  logic [CNT_W-1:0]             column_count;
  logic [CNT_W-1:0]             row_count;

  logic [DIM_W-1:0] width_fit, height_fit;
  logic [CNT_W-1:0] w_last, h_last, c_eff, r_eff, c_flip, r_flip;
  logic             last_col, done, accept;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation      <= yrw_pkg::ROT_0;
      region_width  <= yrw_pkg::WIDTH_RESET;
      region_height <= yrw_pkg::HEIGHT_RESET;
      row_stride    <= yrw_pkg::STRIDE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        yrw_pkg::REG_ROTATION:      rotation      <= cfg_data[yrw_pkg::ROT_W-1:0];
        yrw_pkg::REG_REGION_WIDTH:  region_width  <= cfg_data[yrw_pkg::REGION_W-1:0];
        yrw_pkg::REG_REGION_HEIGHT: region_height <= cfg_data[yrw_pkg::REGION_W-1:0];
        yrw_pkg::REG_ROW_STRIDE:    row_stride    <= cfg_data[yrw_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // region size fitted to 1..MAX_DIM, stride capped at MAX_STRIDE
  always_comb begin
    if (region_width == '0) begin
      width_fit = DIM_W'(1);
    end else if (WCMP'(region_width) > WCMP'(MAX_DIM)) begin
      width_fit = DIM_W'(MAX_DIM);
    end else begin
      width_fit = DIM_W'(region_width);
    end
    if (region_height == '0) begin
      height_fit = DIM_W'(1);
    end else if (WCMP'(region_height) > WCMP'(MAX_DIM)) begin
      height_fit = DIM_W'(MAX_DIM);
    end else begin
      height_fit = DIM_W'(region_height);
    end
    if (SCMP'(row_stride) > SCMP'(MAX_STRIDE)) begin
      q_stride = STR_W'(MAX_STRIDE);
    end else begin
      q_stride = STR_W'(row_stride);
    end
  end

  // position, clamped into the current region
  always_comb begin
    w_last   = CNT_W'(width_fit - DIM_W'(1));
    h_last   = CNT_W'(height_fit - DIM_W'(1));
    c_eff    = (column_count > w_last) ? w_last : column_count;
    r_eff    = (row_count > h_last) ? h_last : row_count;
    c_flip   = w_last - c_eff;
    r_flip   = h_last - r_eff;
    last_col = (c_eff == w_last);
    done     = last_col && (r_eff == h_last);
  end

  // index operands: dest = mul_a * stride + add_b
  always_comb begin
    unique case (rotation)
      yrw_pkg::ROT_0: begin
        q_mul_a = r_eff;
        q_add_b = c_eff;
      end
      yrw_pkg::ROT_90: begin
        q_mul_a = c_eff;
        q_add_b = r_flip;
      end
      yrw_pkg::ROT_180: begin
        q_mul_a = r_flip;
        q_add_b = c_flip;
      end
      default: begin
        q_mul_a = c_flip;
        q_add_b = r_eff;
      end
    endcase
  end

  assign pix_in.ready     = q_ready;
  assign q_valid          = pix_in.valid;
  assign q_pix.pix        = pix_in.payload;
  assign q_pix.frame_done = done;
  assign accept           = pix_in.valid && q_ready;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (done) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (last_col) begin
        column_count <= '0;
        row_count    <= r_eff + CNT_W'(1);
      end else begin
        column_count <= c_eff + CNT_W'(1);
        row_count    <= r_eff;
      end
    end
  end

endmodule

[rtl/yrw_queue.sv]
// small fifo between the front and the back
// no package dependencies
module yrw_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push, pop;

  assign wr_ready = (count != COUNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

endmodule

[rtl/yrw_back.sv]
// back: two-stage color conversion and index arithmetic with output register
// depends on yrw_pkg and yrw_result_if
module yrw_back #(
  parameter int MAX_DIM    = yrw_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_STRIDE = yrw_pkg::MAX_STRIDE_DEFAULT,
  localparam int CNT_W     = $clog2(MAX_DIM),
  localparam int STR_W     = $clog2(MAX_STRIDE) + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  yrw_pkg::pix_class_t q_pix,
  input  logic [CNT_W-1:0]    q_mul_a,
  input  logic [CNT_W-1:0]    q_add_b,
  input  logic [STR_W-1:0]    q_stride,
  yrw_result_if.source        pix_out
);

  localparam int CH_W   = yrw_pkg::CH_W;
  localparam int IDX_W  = yrw_pkg::IDX_W;
  localparam int PROD_W = CNT_W + STR_W;
  localparam int EXT_W  = (PROD_W + 1 > IDX_W) ? PROD_W + 1 : IDX_W;

  logic                   advance;
  logic [7:0]             y_off;
  logic signed [8:0]      u_off, v_off;
  logic signed [CH_W-1:0] y_ext, u_ext, v_ext;

  logic                   s1_valid;
  logic [PROD_W-1:0]      s1_prod;
  logic [CNT_W-1:0]       s1_b;
  logic                   s1_done;
  logic signed [CH_W-1:0] s1_py, s1_prv, s1_pgv, s1_pgu, s1_pbu;

  logic [EXT_W-1:0]       idx_sum;
  logic signed [CH_W-1:0] r_sum, g_sum, b_sum;

  logic                   out_valid;
  yrw_pkg::out_item_t     out_item;

  // the whole back moves when the output register is free or being drained
  assign advance = !out_valid || pix_out.ready;
  assign q_ready = advance;

  // offsets, luma floored at zero
  always_comb begin
    y_off = (q_pix.pix.luma_sample < yrw_pkg::LUMA_OFFSET) ? 8'd0
          : q_pix.pix.luma_sample - yrw_pkg::LUMA_OFFSET;
    u_off = $signed({1'b0, q_pix.pix.blue_diff_sample}) - yrw_pkg::CHROMA_OFFSET;
    v_off = $signed({1'b0, q_pix.pix.red_diff_sample}) - yrw_pkg::CHROMA_OFFSET;
    y_ext = $signed({{(CH_W-8){1'b0}}, y_off});
    u_ext = CH_W'(u_off);
    v_ext = CH_W'(v_off);
  end

  // stage 1: all products
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_prod <= PROD_W'(q_mul_a) * PROD_W'(q_stride);
      s1_b    <= q_add_b;
      s1_done <= q_pix.frame_done;
      s1_py   <= y_ext * yrw_pkg::COEF_Y;
      s1_prv  <= v_ext * yrw_pkg::COEF_RV;
      s1_pgv  <= v_ext * yrw_pkg::COEF_GV;
      s1_pgu  <= u_ext * yrw_pkg::COEF_GU;
      s1_pbu  <= u_ext * yrw_pkg::COEF_BU;
    end
  end

  // stage 2: sums, clamp and packing
  always_comb begin
    idx_sum = EXT_W'(s1_prod) + EXT_W'(s1_b);
    r_sum   = s1_py + s1_prv;
    g_sum   = s1_py - s1_pgv - s1_pgu;
    b_sum   = s1_py + s1_pbu;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.dest_index <= idx_sum[IDX_W-1:0];
      out_item.pixel_rgba <= {yrw_pkg::ALPHA_OPAQUE, yrw_pkg::clamp_chan(r_sum),
                              yrw_pkg::clamp_chan(g_sum), yrw_pkg::clamp_chan(b_sum)};
      out_item.frame_done <= s1_done;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= q_valid;
      out_valid <= s1_valid;
    end
  end

  assign pix_out.valid   = out_valid;
  assign pix_out.payload = out_item;

endmodule

[rtl/yuv_to_rgb_rotate_writer.sv]
// Path: a pixel taken into the queue passes the stage-1 product register, then the output register.
// Throughput: one pixel per cycle; the front takes a pixel whenever the QUEUE_DEPTH-entry queue
// (2 by default) has room, the back drains one entry per cycle while the output register is free or being taken.
// Reset (rst, synchronous): counters to 0, registers to their defaults, queue and stage
// valids cleared; no clearing pass, the block is ready the cycle after reset drops.
module yuv_to_rgb_rotate_writer #(
  parameter int MAX_DIM     = yrw_pkg::MAX_DIM_DEFAULT,
  parameter int MAX_STRIDE  = yrw_pkg::MAX_STRIDE_DEFAULT,
  parameter int QUEUE_DEPTH = yrw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write_en,
  input  logic [yrw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [yrw_pkg::CFG_DATA_W-1:0]  cfg_data,
  yrw_pixel_if.sink                       pix_in,
  yrw_result_if.source                    pix_out
);

  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int STR_W   = $clog2(MAX_STRIDE) + 1;
  localparam int CLASS_W = $bits(yrw_pkg::pix_class_t);
  localparam int ENTRY_W = CLASS_W + 2 * CNT_W + STR_W;

  logic                f_valid, f_ready;
  yrw_pkg::pix_class_t f_pix;
  logic [CNT_W-1:0]    f_mul_a, f_add_b;
  logic [STR_W-1:0]    f_stride;

  logic                b_valid, b_ready;
  logic [ENTRY_W-1:0]  b_entry;
  yrw_pkg::pix_class_t b_pix;
  logic [CNT_W-1:0]    b_mul_a, b_add_b;
  logic [STR_W-1:0]    b_stride;

  // accept, track position, pick index operands
  yrw_front #(
    .MAX_DIM    (MAX_DIM),
    .MAX_STRIDE (MAX_STRIDE)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pix_in       (pix_in),
    .q_valid      (f_valid),
    .q_ready      (f_ready),
    .q_pix        (f_pix),
    .q_mul_a      (f_mul_a),
    .q_add_b      (f_add_b),
    .q_stride     (f_stride)
  );

  // decoupling queue
  yrw_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  ({f_pix, f_mul_a, f_add_b, f_stride}),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_entry)
  );

  assign {b_pix, b_mul_a, b_add_b, b_stride} = b_entry;

  // conversion and index arithmetic
  yrw_back #(
    .MAX_DIM    (MAX_DIM),
    .MAX_STRIDE (MAX_STRIDE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (b_valid),
    .q_ready  (b_ready),
    .q_pix    (b_pix),
    .q_mul_a  (b_mul_a),
    .q_add_b  (b_add_b),
    .q_stride (b_stride),
    .pix_out  (pix_out)
  );

endmodule

[rtl/yrw_checker.sv]
// port-level checker for yuv_to_rgb_rotate_writer, attached by bind
// depends on yrw_pkg and yuv_to_rgb_rotate_writer_defines.svh
`include "yuv_to_rgb_rotate_writer_defines.svh"

module yrw_checker #(
  parameter int QUEUE_DEPTH = yrw_pkg::QUEUE_DEPTH_DEFAULT
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input yrw_pkg::out_item_t out_payload
);

  // queue entries plus the two back stages
  localparam int CAPACITY = QUEUE_DEPTH + 2;
  localparam int OUT_W    = $clog2(CAPACITY + 1);

  logic             in_xfer, out_xfer;
  logic [OUT_W-1:0] outstanding;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_xfer && !out_xfer) begin
      outstanding <= outstanding + OUT_W'(1);
    end else if (out_xfer && !in_xfer) begin
      outstanding <= outstanding - OUT_W'(1);
    end
  end

  `YRW_ASSERT_NOW(no_invented_result, out_valid, outstanding != '0, "result without pending pixel")
  `YRW_ASSERT_NOW(no_overfill, in_xfer, outstanding < OUT_W'(CAPACITY), "pixel taken while full")
  `YRW_ASSERT_NOW(alpha_opaque, out_valid, out_payload.pixel_rgba[31:24] == 8'hff, "alpha not opaque")
  `YRW_ASSERT_NEXT(result_holds, out_valid && !out_ready, out_valid && $stable(out_payload), "stalled result changed")

endmodule

bind yuv_to_rgb_rotate_writer yrw_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_yrw_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pix_in.valid),
  .in_ready    (pix_in.ready),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_payload (pix_out.payload)
);
